### hdl/smp_pkg.sv
// ----------------------------------------------------------------------------
// smp_pkg: shared types and constants for the serial mouse packet decoder
// Item layouts, command codes, packet phases and accumulator helpers.
// ----------------------------------------------------------------------------
package smp_pkg;

  localparam int ACC_WIDTH   = 16;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [15:0] TIMEOUT_RESET = 16'h4000;
  localparam logic [15:0] IDLE_MAX      = 16'hFFFF;

  // input mode codes
  localparam logic [1:0] MODE_BYTE     = 2'd0;
  localparam logic [1:0] MODE_LINE_ERR = 2'd1;
  localparam logic [1:0] MODE_FETCH    = 2'd2;
  localparam logic [1:0] MODE_TICK     = 2'd3;

  // result event codes
  localparam logic [1:0] EV_NONE    = 2'd0;
  localparam logic [1:0] EV_DECODED = 2'd1;
  localparam logic [1:0] EV_FETCH   = 2'd2;
  localparam logic [1:0] EV_ABANDON = 2'd3;

  typedef enum logic [1:0] {
    OP_BYTE,
    OP_LINE_ERR,
    OP_FETCH,
    OP_TICK
  } op_t;

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_X,
    PH_Y
  } phase_t;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         event_kind;
    logic               break_request;
    logic signed [15:0] delta_x;
    logic signed [15:0] delta_y;
    logic [1:0]         button_bits;
    logic               data_pending;
  } out_item_t;

  // classified command handed from front to back
  typedef struct packed {
    op_t        op;
    logic       sync;   // header marker, bit 6 of the byte
    logic [5:0] low6;
  } cmd_t;

  function automatic logic signed [ACC_WIDTH-1:0] sat_add(
    input logic signed [ACC_WIDTH-1:0] acc,
    input logic signed [7:0]           d
  );
    logic signed [ACC_WIDTH:0] s;
    s = (ACC_WIDTH + 1)'(acc) + (ACC_WIDTH + 1)'(d);
    if (s[ACC_WIDTH] != s[ACC_WIDTH-1]) begin
      if (s[ACC_WIDTH]) begin
        sat_add = {1'b1, {(ACC_WIDTH - 1){1'b0}}};
      end else begin
        sat_add = {1'b0, {(ACC_WIDTH - 1){1'b1}}};
      end
    end else begin
      sat_add = s[ACC_WIDTH-1:0];
    end
  endfunction

  // low 16 bits of the sign-extended accumulator
  function automatic logic signed [15:0] acc_to_out(
    input logic signed [ACC_WIDTH-1:0] acc
  );
    logic signed [31:0] ext;
    ext = 32'(acc);
    acc_to_out = ext[15:0];
  endfunction

endpackage

### hdl/serial_mouse_packet_decoder.sv
// ----------------------------------------------------------------------------
// serial_mouse_packet_decoder: three-byte serial mouse decoder
// Assembles header/X/Y bytes into motion, keeps saturating accumulators.
// ----------------------------------------------------------------------------
// Every accepted item yields exactly one result item. Items flow at one per
// cycle sustained unless the output stalls: a classifier pushes each item
// into a four-entry command queue, and the executor retires one command per
// cycle while the result stage can take it, into a registered result stage.
// The queue absorbs up to four items of output backpressure before in_ready
// drops. cfg_data sets the timeout in idle ticks (reset 16384); write it only
// while no item is in flight.
module serial_mouse_packet_decoder (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [15:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  smp_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output smp_pkg::out_item_t out_data
);
  import smp_pkg::*;

  logic q_full;
  logic q_push;
  logic q_pop;
  logic q_valid;
  cmd_t q_wdata;
  cmd_t q_cmd;

  smp_front u_front (
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_wdata  (q_wdata)
  );

  smp_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .wdata   (q_wdata),
    .full    (q_full),
    .pop     (q_pop),
    .q_valid (q_valid),
    .rdata   (q_cmd)
  );

  smp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

### hdl/smp_front.sv
// ----------------------------------------------------------------------------
// smp_front: input classifier
// Turns an incoming item into a command and pushes it into the queue.
// ----------------------------------------------------------------------------
module smp_front (
  input  logic              in_valid,
  output logic              in_ready,
  input  smp_pkg::in_item_t in_data,
  input  logic              q_full,
  output logic              q_push,
  output smp_pkg::cmd_t     q_wdata
);
  import smp_pkg::*;

  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    q_wdata.sync = in_data.data_byte[6];
    q_wdata.low6 = in_data.data_byte[5:0];
    case (in_data.mode)
      MODE_BYTE:     q_wdata.op = OP_BYTE;
      MODE_LINE_ERR: q_wdata.op = OP_LINE_ERR;
      MODE_FETCH:    q_wdata.op = OP_FETCH;
      default:       q_wdata.op = OP_TICK;
    endcase
  end

endmodule

### hdl/smp_queue.sv
// ----------------------------------------------------------------------------
// smp_queue: command queue
// Small FIFO between classifier and executor; push and pop in one cycle.
// ----------------------------------------------------------------------------
module smp_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  smp_pkg::cmd_t wdata,
  output logic          full,
  input  logic          pop,
  output logic          q_valid,
  output smp_pkg::cmd_t rdata
);
  import smp_pkg::*;

  cmd_t              slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;

  assign full    = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign q_valid = (count_r != '0);
  assign rdata   = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

### hdl/smp_back.sv
// ----------------------------------------------------------------------------
// smp_back: packet executor
// Holds packet phase, accumulators and timeout; executes one command a
// cycle, unless the output stalls, into a registered result stage.
// ----------------------------------------------------------------------------
module smp_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [15:0]        cfg_data,
  input  logic               q_valid,
  input  smp_pkg::cmd_t      q_cmd,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_ready,
  output smp_pkg::out_item_t out_data
);
  import smp_pkg::*;

  phase_t                      phase_r, phase_nxt;
  logic [5:0]                  hdr_r, hdr_nxt;
  logic [5:0]                  xlow_r, xlow_nxt;
  logic [15:0]                 idle_r, idle_nxt;
  logic signed [ACC_WIDTH-1:0] acc_x_r, acc_x_nxt;
  logic signed [ACC_WIDTH-1:0] acc_y_r, acc_y_nxt;
  logic [1:0]                  btn_r, btn_nxt;
  logic                        pend_r, pend_nxt;
  logic [15:0]                 timeout_r;
  logic                        out_valid_r;
  out_item_t                   out_data_r;

  logic                        fire;
  logic [15:0]                 idle_inc;
  logic signed [7:0]           pkt_dx, pkt_dy;
  out_item_t                   res;

  assign cfg_ready = 1'b1;
  assign fire      = q_valid && (!out_valid_r || out_ready);
  assign q_pop     = fire;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign idle_inc = (idle_r == IDLE_MAX) ? idle_r : idle_r + 16'd1;
  assign pkt_dx   = {hdr_r[1:0], xlow_r};
  assign pkt_dy   = {hdr_r[3:2], q_cmd.low6};

  always_comb begin
    phase_nxt = phase_r;
    hdr_nxt   = hdr_r;
    xlow_nxt  = xlow_r;
    idle_nxt  = idle_r;
    acc_x_nxt = acc_x_r;
    acc_y_nxt = acc_y_r;
    btn_nxt   = btn_r;
    pend_nxt  = pend_r;
    res       = '0;
    res.event_kind = EV_NONE;
    if (fire) begin
      case (q_cmd.op)
        OP_BYTE: begin
          idle_nxt = '0;
          case (phase_r)
            PH_X: begin
              xlow_nxt  = q_cmd.low6;
              phase_nxt = PH_Y;
            end
            PH_Y: begin
              btn_nxt        = {hdr_r[4], hdr_r[5]};
              acc_x_nxt      = sat_add(acc_x_r, pkt_dx);
              acc_y_nxt      = sat_add(acc_y_r, pkt_dy);
              pend_nxt       = 1'b1;
              phase_nxt      = PH_HEADER;
              res.event_kind = EV_DECODED;
              res.delta_x    = 16'(pkt_dx);
              res.delta_y    = 16'(pkt_dy);
            end
            default: begin
              if (q_cmd.sync) begin
                hdr_nxt   = q_cmd.low6;
                phase_nxt = PH_X;
              end else begin
                phase_nxt         = PH_HEADER;
                res.event_kind    = EV_ABANDON;
                res.break_request = 1'b1;
              end
            end
          endcase
        end
        OP_LINE_ERR: begin
          phase_nxt         = PH_HEADER;
          idle_nxt          = '0;
          res.event_kind    = EV_ABANDON;
          res.break_request = 1'b1;
        end
        OP_FETCH: begin
          res.event_kind = EV_FETCH;
          res.delta_x    = acc_to_out(acc_x_r);
          res.delta_y    = acc_to_out(acc_y_r);
          acc_x_nxt      = '0;
          acc_y_nxt      = '0;
          pend_nxt       = 1'b0;
        end
        default: begin
          if (phase_r == PH_X || phase_r == PH_Y) begin
            idle_nxt = idle_inc;
            // a zero timeout trips on the first tick, same as one
            if (idle_inc >= timeout_r) begin
              phase_nxt      = PH_HEADER;
              idle_nxt       = '0;
              res.event_kind = EV_ABANDON;
            end
          end
        end
      endcase
    end
    res.button_bits  = btn_nxt;
    res.data_pending = (q_cmd.op == OP_FETCH) ? pend_r : pend_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_HEADER;
      hdr_r       <= '0;
      xlow_r      <= '0;
      idle_r      <= '0;
      acc_x_r     <= '0;
      acc_y_r     <= '0;
      btn_r       <= '0;
      pend_r      <= 1'b0;
      timeout_r   <= TIMEOUT_RESET;
      out_valid_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      hdr_r   <= hdr_nxt;
      xlow_r  <= xlow_nxt;
      idle_r  <= idle_nxt;
      acc_x_r <= acc_x_nxt;
      acc_y_r <= acc_y_nxt;
      btn_r   <= btn_nxt;
      pend_r  <= pend_nxt;
      if (cfg_valid && cfg_ready) begin
        timeout_r <= cfg_data;
      end
      if (fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_data_r <= res;
    end
  end

  // completing byte must decode and leave motion pending
  a_decode_sets_pending: assert property (@(posedge clk) disable iff (!rst_n)
    fire && q_cmd.op == OP_BYTE && phase_r == PH_Y |=>
      out_valid_r && out_data_r.event_kind == EV_DECODED && pend_r)
    else $error("decoded packet did not set pending");

  a_fetch_clears: assert property (@(posedge clk) disable iff (!rst_n)
    fire && q_cmd.op == OP_FETCH |=> acc_x_r == '0 && acc_y_r == '0 && !pend_r)
    else $error("fetch did not clear accumulators");

  a_idle_only_mid_packet: assert property (@(posedge clk) disable iff (!rst_n)
    idle_r != '0 |-> phase_r != PH_HEADER)
    else $error("idle count running outside a packet");

  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |=> out_valid_r && $stable(out_data_r))
    else $error("stalled result lost or changed");

endmodule
